[sv/mbse_pkg.sv]
// package: shared constants, codes and types for the middle button scroll emulation core
package mbse_pkg;

  localparam int COORD_BITS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int PORT_COORD  = 16;
  localparam int PORT_TIME   = 32;
  localparam int WHEEL_BITS  = 25;
  localparam int LIMIT_BITS  = 16;
  localparam int SCALE_BITS  = 8;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = (DIFF_BITS + SCALE_BITS + 1 > WHEEL_BITS) ?
                               DIFF_BITS + SCALE_BITS + 1 : WHEEL_BITS;

  localparam logic [LIMIT_BITS-1:0] FAST_LIMIT_RESET  = LIMIT_BITS'(30);
  localparam logic [LIMIT_BITS-1:0] SLOW_LIMIT_RESET  = LIMIT_BITS'(300);
  localparam logic [SCALE_BITS-1:0] SCROLL_SCALE_RESET = SCALE_BITS'(10);

  typedef enum logic [1:0] {
    OP_DOWN  = 2'd0,
    OP_UP    = 2'd1,
    OP_MOVE  = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_ENABLE       = 2'd0,
    REG_FAST_LIMIT   = 2'd1,
    REG_SLOW_LIMIT   = 2'd2,
    REG_SCROLL_SCALE = 2'd3
  } reg_index_t;

endpackage

[sv/middle_button_scroll_emulation_core.sv]
// top level: middle button scroll emulation core, one pointer event in, one result out
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------------
//   in      | input     | in_valid / in_stall   | operation, timestamp_ms, pos_x, pos_y
//   out     | output    | out_valid / out_stall | consumed, emit_click, emit_scroll,
//           |           |                       | warp_cursor, anchor_x/y, wheel_horizontal/vertical
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low; results leave from the result register
// state is read and updated as a request moves from the input register into the result register
// rst (synchronous) clears the state and loads the register defaults
// out_stall holds the result register, and the input register stalls only when both are full
module middle_button_scroll_emulation_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [mbse_pkg::PORT_TIME-1:0]       timestamp_ms,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] pos_x,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] pos_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 consumed,
  output logic                                 emit_click,
  output logic                                 emit_scroll,
  output logic                                 warp_cursor,
  output logic signed [mbse_pkg::PORT_COORD-1:0] anchor_x,
  output logic signed [mbse_pkg::PORT_COORD-1:0] anchor_y,
  output logic signed [mbse_pkg::WHEEL_BITS-1:0] wheel_horizontal,
  output logic signed [mbse_pkg::WHEEL_BITS-1:0] wheel_vertical,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [mbse_pkg::LIMIT_BITS-1:0]      cfg_data
);
  import mbse_pkg::*;

  // configuration
  logic                  enable;
  logic [LIMIT_BITS-1:0] fast_click_limit_ms;
  logic [LIMIT_BITS-1:0] slow_click_limit_ms;
  logic [SCALE_BITS-1:0] scroll_scale;

  // input register
  logic                         s1_valid;
  op_t                          s1_op;
  logic [TIME_BITS-1:0]         s1_time;
  logic signed [COORD_BITS-1:0] s1_x;
  logic signed [COORD_BITS-1:0] s1_y;

  // state
  logic                         button_held, button_held_next;
  logic                         scroll_active, scroll_active_next;
  logic                         fresh_flag, fresh_flag_next;
  logic signed [COORD_BITS-1:0] anchor_x_reg, anchor_x_reg_next;
  logic signed [COORD_BITS-1:0] anchor_y_reg, anchor_y_reg_next;
  logic [TIME_BITS-1:0]         last_down_ms, last_down_ms_next;
  logic [TIME_BITS-1:0]         last_up_ms, last_up_ms_next;

  // result values
  logic                         consumed_next, click_next, scroll_next, warp_next;
  logic signed [WHEEL_BITS-1:0] wheel_h_next, wheel_v_next;

  logic                         in_accept;
  logic                         advance;
  logic [TIME_BITS-1:0]         gap, hold;
  logic [TIME_BITS-1:0]         fast_ext, slow_ext;
  logic signed [DIFF_BITS-1:0]  dx, dy, dx_sel;
  logic [DIFF_BITS-1:0]         mag_x, mag_y;
  logic signed [PROD_BITS-1:0]  prod_h, prod_v, scale_ext;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable              <= 1'b1;
      fast_click_limit_ms <= FAST_LIMIT_RESET;
      slow_click_limit_ms <= SLOW_LIMIT_RESET;
      scroll_scale        <= SCROLL_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLE:       enable              <= cfg_data[0];
        REG_FAST_LIMIT:   fast_click_limit_ms <= cfg_data;
        REG_SLOW_LIMIT:   slow_click_limit_ms <= cfg_data;
        REG_SCROLL_SCALE: scroll_scale        <= cfg_data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !advance);
    end
    if (in_accept) begin
      s1_op   <= op_t'(operation);
      s1_time <= TIME_BITS'(timestamp_ms);
      s1_x    <= COORD_BITS'(pos_x);
      s1_y    <= COORD_BITS'(pos_y);
    end
  end

  assign fast_ext  = TIME_BITS'(fast_click_limit_ms);
  assign slow_ext  = TIME_BITS'(slow_click_limit_ms);
  assign gap       = s1_time - last_up_ms;
  assign hold      = s1_time - last_down_ms;
  assign dx        = DIFF_BITS'(anchor_x_reg) - DIFF_BITS'(s1_x);
  assign dy        = DIFF_BITS'(anchor_y_reg) - DIFF_BITS'(s1_y);
  assign mag_x     = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
  assign mag_y     = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
  assign dx_sel    = (mag_y > mag_x) ? '0 : dx;
  assign scale_ext = PROD_BITS'(scroll_scale);
  assign prod_h    = PROD_BITS'(dx_sel) * scale_ext;
  assign prod_v    = PROD_BITS'(dy) * scale_ext;

  always_comb begin
    button_held_next   = button_held;
    scroll_active_next = scroll_active;
    fresh_flag_next    = fresh_flag;
    anchor_x_reg_next  = anchor_x_reg;
    anchor_y_reg_next  = anchor_y_reg;
    last_down_ms_next  = last_down_ms;
    last_up_ms_next    = last_up_ms;
    consumed_next      = 1'b0;
    click_next         = 1'b0;
    scroll_next        = 1'b0;
    warp_next          = 1'b0;
    wheel_h_next       = '0;
    wheel_v_next       = '0;
    if (enable) begin
      case (s1_op)
        OP_DOWN: begin
          if (fresh_flag) begin
            button_held_next = 1'b1;
            if (!scroll_active || gap > fast_ext) begin
              scroll_active_next = 1'b0;
              anchor_x_reg_next  = s1_x;
              anchor_y_reg_next  = s1_y;
            end
            last_down_ms_next = s1_time;
            consumed_next     = 1'b1;
          end
        end
        OP_UP: begin
          if (fresh_flag) begin
            button_held_next = 1'b0;
            if (!scroll_active && hold > fast_ext && hold < slow_ext) begin
              fresh_flag_next = 1'b0;
              click_next      = 1'b1;
            end
            last_up_ms_next = s1_time;
            consumed_next   = 1'b1;
          end else begin
            fresh_flag_next = 1'b1;
          end
        end
        OP_MOVE: begin
          if (button_held) begin
            scroll_active_next = 1'b1;
            wheel_h_next       = prod_h[WHEEL_BITS-1:0];
            wheel_v_next       = prod_v[WHEEL_BITS-1:0];
            warp_next          = 1'b1;
            scroll_next        = 1'b1;
            consumed_next      = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held   <= 1'b0;
      scroll_active <= 1'b0;
      fresh_flag    <= 1'b1;
      anchor_x_reg  <= '0;
      anchor_y_reg  <= '0;
      last_down_ms  <= '0;
      last_up_ms    <= '0;
    end else if (advance) begin
      button_held   <= button_held_next;
      scroll_active <= scroll_active_next;
      fresh_flag    <= fresh_flag_next;
      anchor_x_reg  <= anchor_x_reg_next;
      anchor_y_reg  <= anchor_y_reg_next;
      last_down_ms  <= last_down_ms_next;
      last_up_ms    <= last_up_ms_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
    if (advance) begin
      consumed         <= consumed_next;
      emit_click       <= click_next;
      emit_scroll      <= scroll_next;
      warp_cursor      <= warp_next;
      anchor_x         <= PORT_COORD'(anchor_x_reg_next);
      anchor_y         <= PORT_COORD'(anchor_y_reg_next);
      wheel_horizontal <= wheel_h_next;
      wheel_vertical   <= wheel_v_next;
    end
  end

  a_scroll_warps: assert property (@(posedge clk) disable iff (rst)
    out_valid && emit_scroll |-> warp_cursor && consumed && !emit_click)
    else $error("scroll result without warp or consume");

  a_click_clears_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && emit_click |-> consumed && !fresh_flag && !button_held)
    else $error("click result while fresh or held");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(anchor_x_reg) && $stable(fresh_flag) && $stable(last_up_ms))
    else $error("state changed without a request moving");

endmodule

[bench/scroll_result_checker.sv]
// checker: predicts every scroll emulation result and compares it with what the core delivers
module scroll_result_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [1:0]                             operation,
  input  logic [mbse_pkg::PORT_TIME-1:0]         timestamp_ms,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] pos_x,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] pos_y,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic                                   consumed,
  input  logic                                   emit_click,
  input  logic                                   emit_scroll,
  input  logic                                   warp_cursor,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] anchor_x,
  input  logic signed [mbse_pkg::PORT_COORD-1:0] anchor_y,
  input  logic signed [mbse_pkg::WHEEL_BITS-1:0] wheel_horizontal,
  input  logic signed [mbse_pkg::WHEEL_BITS-1:0] wheel_vertical,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [mbse_pkg::LIMIT_BITS-1:0]        cfg_data,
  output int                                     errors,
  output int                                     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbse_pkg::*;

  typedef struct packed {
    logic                         consumed;
    logic                         click;
    logic                         scroll;
    logic                         warp;
    logic signed [PORT_COORD-1:0] ax;
    logic signed [PORT_COORD-1:0] ay;
    logic signed [WHEEL_BITS-1:0] wh;
    logic signed [WHEEL_BITS-1:0] wv;
  } pointer_result_t;

  pointer_result_t awaited_results[$];
  int              results_seen;

  logic                  en_q;
  logic [LIMIT_BITS-1:0] fast_ms_q;
  logic [LIMIT_BITS-1:0] slow_ms_q;
  logic [SCALE_BITS-1:0] scale_q;

  logic                         held_q;
  logic                         scrolling_q;
  logic                         fresh_q;
  logic signed [PORT_COORD-1:0] anc_x_q;
  logic signed [PORT_COORD-1:0] anc_y_q;
  logic [PORT_TIME-1:0]         down_ms_q;
  logic [PORT_TIME-1:0]         up_ms_q;

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task clear_state();
    en_q = 1'b1;
    fast_ms_q = FAST_LIMIT_RESET;
    slow_ms_q = SLOW_LIMIT_RESET;
    scale_q = SCROLL_SCALE_RESET;
    held_q = 1'b0;
    scrolling_q = 1'b0;
    fresh_q = 1'b1;
    anc_x_q = '0;
    anc_y_q = '0;
    down_ms_q = '0;
    up_ms_q = '0;
  endtask

  task predict_event(input op_t op, input logic [PORT_TIME-1:0] ts,
                     input logic signed [PORT_COORD-1:0] x,
                     input logic signed [PORT_COORD-1:0] y, output pointer_result_t r);
    logic [PORT_TIME-1:0] elapsed;
    int dx, dy, adx, ady;
    r = '0;
    if (en_q) begin
      case (op)
        OP_DOWN: begin
          if (fresh_q) begin
            elapsed = ts - up_ms_q;
            held_q = 1'b1;
            if (!scrolling_q || elapsed > fast_ms_q) begin
              scrolling_q = 1'b0;
              anc_x_q = x;
              anc_y_q = y;
            end
            down_ms_q = ts;
            r.consumed = 1'b1;
          end
        end
        OP_UP: begin
          if (fresh_q) begin
            elapsed = ts - down_ms_q;
            held_q = 1'b0;
            if (!scrolling_q && elapsed > fast_ms_q && elapsed < slow_ms_q) begin
              fresh_q = 1'b0;
              r.click = 1'b1;
            end
            up_ms_q = ts;
            r.consumed = 1'b1;
          end else begin
            fresh_q = 1'b1;
          end
        end
        OP_MOVE: begin
          if (held_q) begin
            dx = int'(anc_x_q) - int'(x);
            dy = int'(anc_y_q) - int'(y);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            scrolling_q = 1'b1;
            // vertical wins only when strictly larger
            if (ady > adx) dx = 0;
            r.wh = WHEEL_BITS'(dx * int'(scale_q));
            r.wv = WHEEL_BITS'(dy * int'(scale_q));
            r.warp = 1'b1;
            r.scroll = 1'b1;
            r.consumed = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.ax = anc_x_q;
    r.ay = anc_y_q;
  endtask

  task check_field(string name, longint want, longint got);
    if (want != got)
      report($sformatf("result %0d: %s expected %0d got %0d", results_seen, name, want, got));
  endtask

  task compare_result(pointer_result_t want, pointer_result_t got);
    check_field("consumed", want.consumed, got.consumed);
    check_field("emit_click", want.click, got.click);
    check_field("emit_scroll", want.scroll, got.scroll);
    check_field("warp_cursor", want.warp, got.warp);
    check_field("anchor_x", want.ax, got.ax);
    check_field("anchor_y", want.ay, got.ay);
    check_field("wheel_horizontal", want.wh, got.wh);
    check_field("wheel_vertical", want.wv, got.wv);
  endtask

  always @(posedge clk) begin : monitor
    pointer_result_t got;
    pointer_result_t want;
    if (rst) begin
      clear_state();
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ENABLE:       en_q = cfg_data[0];
          REG_FAST_LIMIT:   fast_ms_q = cfg_data;
          REG_SLOW_LIMIT:   slow_ms_q = cfg_data;
          REG_SCROLL_SCALE: scale_q = cfg_data[SCALE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{consumed, emit_click, emit_scroll, warp_cursor, anchor_x, anchor_y,
                wheel_horizontal, wheel_vertical};
        results_seen++;
        if (awaited_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = awaited_results.pop_front();
          compare_result(want, got);
        end
      end
      if (in_valid && !in_stall) begin
        predict_event(op_t'(operation), timestamp_ms, pos_x, pos_y, want);
        awaited_results.push_back(want);
      end
    end
    pending <= awaited_results.size();
  end

endmodule

[bench/tb_middle_button_scroll_emulation_core.sv]
// testbench top: drives pointer event requests and register writes, gives the verdict
module tb_middle_button_scroll_emulation_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mbse_pkg::*;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   operation = OP_OTHER;
  logic [PORT_TIME-1:0]         timestamp_ms = '0;
  logic signed [PORT_COORD-1:0] pos_x = '0;
  logic signed [PORT_COORD-1:0] pos_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         consumed;
  logic                         emit_click;
  logic                         emit_scroll;
  logic                         warp_cursor;
  logic signed [PORT_COORD-1:0] anchor_x;
  logic signed [PORT_COORD-1:0] anchor_y;
  logic signed [WHEEL_BITS-1:0] wheel_horizontal;
  logic signed [WHEEL_BITS-1:0] wheel_vertical;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index = REG_ENABLE;
  logic [LIMIT_BITS-1:0]        cfg_data = '0;

  int                    errors;
  int                    pending;
  int                    items_sent = 0;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  logic [LIMIT_BITS-1:0] fast_lim = FAST_LIMIT_RESET;
  logic [LIMIT_BITS-1:0] slow_lim = SLOW_LIMIT_RESET;
  logic [PORT_TIME-1:0]  now_ms = '0;

  middle_button_scroll_emulation_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .timestamp_ms(timestamp_ms), .pos_x(pos_x), .pos_y(pos_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .consumed(consumed), .emit_click(emit_click), .emit_scroll(emit_scroll),
    .warp_cursor(warp_cursor), .anchor_x(anchor_x), .anchor_y(anchor_y),
    .wheel_horizontal(wheel_horizontal), .wheel_vertical(wheel_vertical),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scroll_result_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .timestamp_ms(timestamp_ms), .pos_x(pos_x), .pos_y(pos_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .consumed(consumed), .emit_click(emit_click), .emit_scroll(emit_scroll),
    .warp_cursor(warp_cursor), .anchor_x(anchor_x), .anchor_y(anchor_y),
    .wheel_horizontal(wheel_horizontal), .wheel_vertical(wheel_vertical),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [PORT_TIME-1:0] near_limit(logic [LIMIT_BITS-1:0] lim);
    case ($urandom_range(6))
      0: return PORT_TIME'(lim);
      1: return PORT_TIME'(lim) + 1;
      2: return PORT_TIME'(lim) - 1;
      3: return $urandom_range(64);
      4: return $urandom;
      default: return $urandom_range(0, 2 * int'(lim) + 2);
    endcase
  endfunction

  task automatic send_event(op_t op, logic [PORT_TIME-1:0] ts, logic [PORT_COORD-1:0] x,
                            logic [PORT_COORD-1:0] y);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    timestamp_ms <= ts;
    pos_x <= x;
    pos_y <= y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic cfg_write(reg_index_t idx, logic [LIMIT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_registers(logic en, logic [LIMIT_BITS-1:0] fl,
                                   logic [LIMIT_BITS-1:0] sl, logic [SCALE_BITS-1:0] sc);
    // upper bits of the narrow registers carry noise
    cfg_write(REG_ENABLE, {15'($urandom), en});
    cfg_write(REG_FAST_LIMIT, fl);
    cfg_write(REG_SLOW_LIMIT, sl);
    cfg_write(REG_SCROLL_SCALE, {8'($urandom), sc});
    cfg_valid <= 1'b0;
    fast_lim = fl;
    slow_lim = sl;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_event(OP_MOVE, 32'd0, 16'd100, 16'd100);
    send_event(OP_UP, 32'hFFFF_FFFF, 16'h0000, 16'h0000);
    send_event(OP_DOWN, 32'd1000, 16'h7FFF, 16'h8000);
    send_event(OP_MOVE, 32'd1001, 16'h8000, 16'h7FFF);
    send_event(OP_MOVE, 32'd1002, 16'h7FF0, 16'h8010);
    send_event(OP_OTHER, 32'd1003, 16'hFFFF, 16'hFFFF);
    send_event(OP_UP, 32'd1100, 16'd3, 16'd3);
    send_event(OP_DOWN, 32'd1110, 16'd1, 16'd1);
    send_event(OP_UP, 32'd1130, 16'd1, 16'd1);
    send_event(OP_DOWN, 32'd2000, 16'd5, 16'd7);
    send_event(OP_UP, 32'd2031, 16'd5, 16'd7);
    send_event(OP_DOWN, 32'd2100, 16'd9, 16'd9);
    send_event(OP_MOVE, 32'd2101, 16'd20, 16'd20);
    send_event(OP_UP, 32'd2200, 16'd9, 16'd9);
    send_event(OP_DOWN, 32'd3000, 16'hFFFD, 16'd4);
    send_event(OP_UP, 32'd3030, 16'hFFFD, 16'd4);
    send_event(OP_DOWN, 32'd4000, 16'd2, 16'd2);
    send_event(OP_UP, 32'd4300, 16'd2, 16'd2);
    send_event(OP_DOWN, 32'd5000, 16'd6, 16'd6);
    send_event(OP_UP, 32'd5299, 16'd6, 16'd6);
    send_event(OP_UP, 32'd5300, 16'd6, 16'd6);
    // hold measured across the timestamp wrap
    send_event(OP_DOWN, 32'hFFFF_FFF0, 16'hFFFF, 16'h0000);
    send_event(OP_UP, 32'h0000_0020, 16'hFFFF, 16'h0000);
    send_event(OP_UP, 32'h0000_0021, 16'h0000, 16'h0000);
    send_event(OP_MOVE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic run_random(int count);
    int target;
    int nmov;
    logic [PORT_COORD-1:0] ax;
    logic [PORT_COORD-1:0] ay;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 20) begin
        send_event(op_t'($urandom_range(3)), $urandom, 16'($urandom), 16'($urandom));
      end else begin
        // press, optional drag, release with timing near the click limits
        now_ms = now_ms + near_limit(fast_lim);
        ax = 16'($urandom);
        ay = 16'($urandom);
        send_event(OP_DOWN, now_ms, ax, ay);
        nmov = $urandom_range(1) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < nmov; i++) begin
          if ($urandom_range(3) == 0)
            send_event(OP_MOVE, now_ms + i, 16'($urandom), 16'($urandom));
          else
            send_event(OP_MOVE, now_ms + i, ax + 16'($urandom_range(64)) - 16'd32,
                       ay + 16'($urandom_range(64)) - 16'd32);
        end
        if ($urandom_range(9) == 0)
          send_event(OP_OTHER, now_ms, 16'($urandom), 16'($urandom));
        now_ms = now_ms + near_limit($urandom_range(1) ? fast_lim : slow_lim);
        send_event(OP_UP, now_ms, 16'($urandom), 16'($urandom));
        if ($urandom_range(3) == 0)
          send_event(OP_UP, now_ms + 1, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    logic                  en;
    logic [LIMIT_BITS-1:0] fl;
    logic [LIMIT_BITS-1:0] sl;
    logic [SCALE_BITS-1:0] sc;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    now_ms = $urandom;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          en = 1'b1; fl = FAST_LIMIT_RESET; sl = SLOW_LIMIT_RESET; sc = SCROLL_SCALE_RESET;
          tx_idle_pct = 0; rx_stall_pct = 0;
        end
        1: begin
          en = 1'b1; fl = 16'd0; sl = 16'hFFFF; sc = 8'hFF;
          tx_idle_pct = 45; rx_stall_pct = 0;
        end
        2: begin
          en = 1'b1; fl = 16'hFFFF; sl = 16'd0; sc = 8'd0;
          tx_idle_pct = 0; rx_stall_pct = 45;
        end
        3: begin
          en = 1'b0; fl = 16'($urandom); sl = 16'($urandom); sc = 8'($urandom);
          tx_idle_pct = 11; rx_stall_pct = 11;
        end
        4: begin
          en = 1'b1; fl = 16'($urandom_range(100)); sl = 16'($urandom_range(100, 1000));
          sc = 8'($urandom);
          tx_idle_pct = 0; rx_stall_pct = 0;
        end
        5: begin
          en = 1'b1; fl = 16'd5; sl = 16'd6; sc = 8'd1;
          tx_idle_pct = 11; rx_stall_pct = 11;
        end
        6: begin
          en = 1'b1; fl = 16'($urandom); sl = 16'($urandom); sc = 8'($urandom);
          tx_idle_pct = 45; rx_stall_pct = 0;
        end
        default: begin
          en = 1'b1; fl = FAST_LIMIT_RESET; sl = SLOW_LIMIT_RESET; sc = SCROLL_SCALE_RESET;
          tx_idle_pct = 0; rx_stall_pct = 45;
        end
      endcase
      program_registers(en, fl, sl, sc);
      if (phase == 0) run_directed();
      run_random((phase == 3) ? 40 : 160);
    end
    wait_idle();
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
